// ----- rtl/core/tnp_pkg.sv -----
// ----------------------------------------------------------------------------
// Tone note player package
// Shared widths, reset values, register indexes, phase and item kind codes,
// and the queue item type.
// ----------------------------------------------------------------------------
package tnp_pkg;

    localparam int CLOCK_HZ_W  = 24;
    localparam int MPT_W       = 10;
    localparam int GAP_W       = 8;
    localparam int FREQ_W      = 16;
    localparam int DUR_W       = 16;
    localparam int DIV_W       = 16;
    localparam int PHASE_W     = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int DIVIDEND_W  = 24;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET = 24'd1193180;
    localparam logic [MPT_W-1:0]      MPT_RESET      = 10'd10;
    localparam logic [GAP_W-1:0]      GAP_RESET      = 8'd2;
    localparam logic [DIV_W-1:0]      RELOAD_RESET   = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MS_PER_TICK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TONE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_REST = 2'd2;
    localparam logic [PHASE_W-1:0] PH_GAP  = 2'd3;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_TICK = 2'd0;
    localparam kind_t KIND_TONE = 2'd1;
    localparam kind_t KIND_REST = 2'd2;

    typedef struct packed {
        kind_t             kind;
        logic [FREQ_W-1:0] freq_hz;
        logic [DUR_W-1:0]  note_ms;
        logic              more_notes;
    } item_t;

endpackage

// ----- rtl/core/tnp_front.sv -----
// ----------------------------------------------------------------------------
// Tone note player front end
// Registers each input transfer, classifies it as tick, tone or rest, and
// pushes it into the command queue.
// ----------------------------------------------------------------------------
module tnp_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [tnp_pkg::FREQ_W-1:0]  s_freq_hz,
    input  logic [tnp_pkg::DUR_W-1:0]   s_note_ms,
    input  logic                        s_more_notes,
    output logic                        push_valid,
    input  logic                        push_ready,
    output tnp_pkg::item_t              push_item
);

    logic           valid_reg;
    logic           valid_next;
    tnp_pkg::item_t item_reg;
    tnp_pkg::item_t item_next;

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        valid_next = valid_reg && !push_ready;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next           = 1'b1;
            item_next.freq_hz    = s_freq_hz;
            item_next.note_ms    = s_note_ms;
            item_next.more_notes = s_more_notes;
            if (s_op) begin
                item_next.kind = tnp_pkg::KIND_TICK;
            end else if (s_freq_hz == '0) begin
                item_next.kind = tnp_pkg::KIND_REST;
            end else begin
                item_next.kind = tnp_pkg::KIND_TONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

// ----- rtl/core/tnp_queue.sv -----
// ----------------------------------------------------------------------------
// Tone note player command queue
// Small first-in first-out buffer that decouples the front end from the
// note sequencer.
// ----------------------------------------------------------------------------
module tnp_queue #(
    parameter int DEPTH = tnp_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tnp_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output tnp_pkg::item_t out_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tnp_pkg::item_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push;
    logic           do_pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/core/tnp_back.sv -----
// ----------------------------------------------------------------------------
// Tone note player sequencer
// Holds the configuration and play state, runs a serial divider for note
// length and reload value, and registers one result per command.
// ----------------------------------------------------------------------------
module tnp_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tnp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tnp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  tnp_pkg::item_t                   q_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_speaker_gate,
    output logic [tnp_pkg::DIV_W-1:0]        m_divisor,
    output logic [tnp_pkg::PHASE_W-1:0]      m_phase,
    output logic                             m_note_done,
    output logic                             m_rejected
);

    localparam logic [1:0] B_IDLE      = 2'd0;
    localparam logic [1:0] B_DIV_TICKS = 2'd1;
    localparam logic [1:0] B_DIV_FREQ  = 2'd2;

    localparam int DW = tnp_pkg::DIVIDEND_W;
    localparam int QW = tnp_pkg::DIV_W;
    localparam int NW = tnp_pkg::DIV_CNT_W;

    logic [tnp_pkg::CLOCK_HZ_W-1:0] clock_hz_reg;
    logic [tnp_pkg::MPT_W-1:0]      mpt_reg;
    logic [tnp_pkg::GAP_W-1:0]      gap_reg;

    logic [1:0]                   state_reg, state_next;
    logic [QW-1:0]                ticks_reg, ticks_next;
    logic [tnp_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic                         gap_pend_reg, gap_pend_next;
    logic [QW-1:0]                reload_reg, reload_next;
    logic                         gate_reg, gate_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         done_reg, done_next;
    logic                         rej_reg, rej_next;
    tnp_pkg::item_t               item_reg, item_next;
    logic [DW-1:0]                quo_reg, quo_next;
    logic [QW-1:0]                rem_reg, rem_next;
    logic [QW-1:0]                den_reg, den_next;
    logic [NW-1:0]                cnt_reg, cnt_next;

    logic [QW:0]   rem_shift;
    logic [QW:0]   rem_sub;
    logic          rem_ge;
    logic [QW-1:0] rem_step;
    logic [DW-1:0] quo_step;
    logic [QW-1:0] tick_dec;
    logic          out_free;

    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_speaker_gate = gate_reg;
    assign m_divisor      = reload_reg;
    assign m_phase        = phase_reg;
    assign m_note_done    = done_reg;
    assign m_rejected     = rej_reg;
    assign out_free       = !m_valid_reg || m_ready;
    assign q_ready        = (state_reg == B_IDLE) && out_free;

    assign rem_shift = {rem_reg, quo_reg[DW-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign rem_step  = rem_ge ? rem_sub[QW-1:0] : rem_shift[QW-1:0];
    assign quo_step  = {quo_reg[DW-2:0], rem_ge};
    assign tick_dec  = (ticks_reg != '0) ? ticks_reg - 1'b1 : '0;

    always_comb begin
        state_next    = state_reg;
        ticks_next    = ticks_reg;
        phase_next    = phase_reg;
        gap_pend_next = gap_pend_reg;
        reload_next   = reload_reg;
        gate_next     = gate_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        done_next     = done_reg;
        rej_next      = rej_reg;
        item_next     = item_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        cnt_next      = cnt_reg;
        unique case (state_reg) inside
            B_IDLE: begin
                if (q_valid && out_free) begin
                    m_valid_next = 1'b1;
                    done_next    = 1'b0;
                    rej_next     = 1'b0;
                    unique case (q_item.kind) inside
                        tnp_pkg::KIND_TONE, tnp_pkg::KIND_REST: begin
                            if (phase_reg != tnp_pkg::PH_IDLE) begin
                                rej_next = 1'b1;
                            end else begin
                                m_valid_next = 1'b0;
                                item_next    = q_item;
                                quo_next     = DW'(q_item.note_ms);
                                rem_next     = '0;
                                den_next     = (mpt_reg == '0) ? QW'(1) : QW'(mpt_reg);
                                cnt_next     = '0;
                                state_next   = B_DIV_TICKS;
                            end
                        end
                        default: begin
                            if (phase_reg != tnp_pkg::PH_IDLE) begin
                                ticks_next = tick_dec;
                                if (tick_dec == '0) begin
                                    gate_next     = 1'b0;
                                    gap_pend_next = 1'b0;
                                    if (phase_reg != tnp_pkg::PH_GAP && gap_pend_reg &&
                                        gap_reg != '0) begin
                                        phase_next = tnp_pkg::PH_GAP;
                                        ticks_next = QW'(gap_reg);
                                    end else begin
                                        phase_next = tnp_pkg::PH_IDLE;
                                        done_next  = 1'b1;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            B_DIV_TICKS, B_DIV_FREQ: begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == NW'(DW - 1)) begin
                    if (state_reg == B_DIV_TICKS) begin
                        ticks_next    = (quo_step[QW-1:0] == '0) ? QW'(1) : quo_step[QW-1:0];
                        gap_pend_next = item_reg.more_notes;
                        if (item_reg.kind == tnp_pkg::KIND_REST) begin
                            gate_next    = 1'b0;
                            phase_next   = tnp_pkg::PH_REST;
                            m_valid_next = 1'b1;
                            state_next   = B_IDLE;
                        end else begin
                            quo_next   = clock_hz_reg;
                            rem_next   = '0;
                            den_next   = item_reg.freq_hz;
                            cnt_next   = '0;
                            state_next = B_DIV_FREQ;
                        end
                    end else begin
                        if (quo_step[DW-1:QW] != '0) begin
                            reload_next = '1;
                        end else if (quo_step[QW-1:0] == '0) begin
                            reload_next = QW'(1);
                        end else begin
                            reload_next = quo_step[QW-1:0];
                        end
                        gate_next    = 1'b1;
                        phase_next   = tnp_pkg::PH_TONE;
                        m_valid_next = 1'b1;
                        state_next   = B_IDLE;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= tnp_pkg::CLOCK_HZ_RESET;
            mpt_reg      <= tnp_pkg::MPT_RESET;
            gap_reg      <= tnp_pkg::GAP_RESET;
            state_reg    <= B_IDLE;
            ticks_reg    <= '0;
            phase_reg    <= tnp_pkg::PH_IDLE;
            gap_pend_reg <= 1'b0;
            reload_reg   <= tnp_pkg::RELOAD_RESET;
            gate_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    tnp_pkg::REG_CLOCK_HZ:    clock_hz_reg <= cfg_data;
                    tnp_pkg::REG_MS_PER_TICK: mpt_reg <= cfg_data[tnp_pkg::MPT_W-1:0];
                    tnp_pkg::REG_GAP_TICKS:   gap_reg <= cfg_data[tnp_pkg::GAP_W-1:0];
                    default: begin
                    end
                endcase
            end
            state_reg    <= state_next;
            ticks_reg    <= ticks_next;
            phase_reg    <= phase_next;
            gap_pend_reg <= gap_pend_next;
            reload_reg   <= reload_next;
            gate_reg     <= gate_next;
            m_valid_reg  <= m_valid_next;
        end
        done_reg <= done_next;
        rej_reg  <= rej_next;
        item_reg <= item_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
    end

    a_div_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != B_IDLE) |-> !m_valid_reg)
        else $error("result pending while the divider is running");

    a_gate_off_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == tnp_pkg::PH_IDLE || phase_reg == tnp_pkg::PH_GAP) |-> !gate_reg)
        else $error("speaker gated on while idle or in a gap");

    a_done_rej_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(done_reg && rej_reg))
        else $error("note done and rejected in the same result");

    a_reload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        reload_reg != '0)
        else $error("reload value is zero");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && done_reg) |-> (phase_reg == tnp_pkg::PH_IDLE))
        else $error("note done reported while still playing");

endmodule

// ----- rtl/core/tone_note_player.sv -----
// ----------------------------------------------------------------------------
// Tone note player
// Path: a tick or a rejected note passes the front end register, the queue and
// the result register; a rest also runs the tick count divide, a tone also the reload divide.
// Throughput: one item per cycle for ticks while no divide runs and m_ready is
// high; notes use the shared serial divider, one quotient bit per cycle.
// Reset: aresetn is synchronous and active low; it restores the default
// configuration, an idle player with the speaker off and reload value 65535.
// ----------------------------------------------------------------------------
module tone_note_player #(
    parameter int QUEUE_DEPTH = tnp_pkg::QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tnp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tnp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [tnp_pkg::FREQ_W-1:0]       s_freq_hz,
    input  logic [tnp_pkg::DUR_W-1:0]        s_note_ms,
    input  logic                             s_more_notes,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_speaker_gate,
    output logic [tnp_pkg::DIV_W-1:0]        m_divisor,
    output logic [tnp_pkg::PHASE_W-1:0]      m_phase,
    output logic                             m_note_done,
    output logic                             m_rejected
);

    logic           push_valid;
    logic           push_ready;
    tnp_pkg::item_t push_item;
    logic           q_valid;
    logic           q_ready;
    tnp_pkg::item_t q_item;

    tnp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_freq_hz     (s_freq_hz),
        .s_note_ms     (s_note_ms),
        .s_more_notes  (s_more_notes),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    tnp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    tnp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_speaker_gate (m_speaker_gate),
        .m_divisor      (m_divisor),
        .m_phase        (m_phase),
        .m_note_done    (m_note_done),
        .m_rejected     (m_rejected)
    );

endmodule

// ----- test/tnp_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tone note player test codes
// Item operation codes that are shared by the test's stimulus and its checker.
// ----------------------------------------------------------------------------
package tnp_tb_pkg;

    localparam logic OP_NOTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

// ----- test/tone_note_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tone note player checker
// Watches the register, item and result channels. It keeps its own copy of the
// player state and settings, works out the result of each accepted item, and
// compares every result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tone_note_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tnp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tnp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_op,
    input  logic [tnp_pkg::FREQ_W-1:0]       s_freq_hz,
    input  logic [tnp_pkg::DUR_W-1:0]        s_note_ms,
    input  logic                             s_more_notes,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_speaker_gate,
    input  logic [tnp_pkg::DIV_W-1:0]        m_divisor,
    input  logic [tnp_pkg::PHASE_W-1:0]      m_phase,
    input  logic                             m_note_done,
    input  logic                             m_rejected,
    output int                               fail_count,
    output int                               outstanding,
    output int                               notes_finished,
    output int                               notes_rejected
);
    import tnp_pkg::*;
    import tnp_tb_pkg::*;

    typedef struct packed {
        logic               speaker_gate;
        logic [DIV_W-1:0]   divisor;
        logic [PHASE_W-1:0] phase;
        logic               note_done;
        logic               rejected;
    } player_out_t;

    logic [CLOCK_HZ_W-1:0] clock_hz_cfg;
    logic [MPT_W-1:0]      mpt_cfg;
    logic [GAP_W-1:0]      gap_cfg;

    logic [DUR_W-1:0]      ticks_left;
    logic [PHASE_W-1:0]    play_phase;
    logic                  gap_pending;
    logic [DIV_W-1:0]      reload_value;
    logic                  gate_on;

    player_out_t pending_outputs[$];
    player_out_t want;
    player_out_t got;
    int          errors;
    int          finished;
    int          rejected_cnt;

    task automatic report_failure(input string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [DIV_W-1:0] seen,
                               input logic [DIV_W-1:0] wanted);
        if (seen !== wanted) begin
            report_failure($sformatf("%s mismatch: got %0d, expected %0d", name, seen, wanted));
        end
    endtask

    function automatic player_out_t next_player_output(input logic op,
                                                       input logic [FREQ_W-1:0] freq,
                                                       input logic [DUR_W-1:0] dur,
                                                       input logic more);
        player_out_t r;
        int unsigned step_ms;
        int unsigned span;
        int unsigned quot;
        r = '0;
        if (op == OP_NOTE) begin
            if (play_phase != PH_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                step_ms = (mpt_cfg == '0) ? 1 : 32'(mpt_cfg);
                span = 32'(dur) / step_ms;
                if (span == 0) span = 1;
                ticks_left = span[DUR_W-1:0];
                gap_pending = more;
                if (freq == '0) begin
                    gate_on = 1'b0;
                    play_phase = PH_REST;
                end else begin
                    quot = 32'(clock_hz_cfg) / 32'(freq);
                    if (quot > 32'hFFFF) quot = 32'hFFFF;
                    if (quot < 1) quot = 1;
                    reload_value = quot[DIV_W-1:0];
                    gate_on = 1'b1;
                    play_phase = PH_TONE;
                end
            end
        end else if (play_phase != PH_IDLE) begin
            if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
            if (ticks_left == '0) begin
                gate_on = 1'b0;
                if (play_phase != PH_GAP && gap_pending && gap_cfg != '0) begin
                    play_phase = PH_GAP;
                    ticks_left = {{(DUR_W-GAP_W){1'b0}}, gap_cfg};
                    gap_pending = 1'b0;
                end else begin
                    play_phase = PH_IDLE;
                    gap_pending = 1'b0;
                    r.note_done = 1'b1;
                end
            end
        end
        r.speaker_gate = gate_on;
        r.divisor = reload_value;
        r.phase = play_phase;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_cfg = CLOCK_HZ_RESET;
            mpt_cfg = MPT_RESET;
            gap_cfg = GAP_RESET;
            ticks_left = '0;
            play_phase = PH_IDLE;
            gap_pending = 1'b0;
            reload_value = RELOAD_RESET;
            gate_on = 1'b0;
            pending_outputs.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_speaker_gate, m_divisor, m_phase, m_note_done, m_rejected};
                if (pending_outputs.size() == 0) begin
                    report_failure($sformatf("result transfer with nothing expected: %h", got));
                end else begin
                    want = pending_outputs.pop_front();
                    check_field("speaker_gate", DIV_W'(got.speaker_gate),
                                DIV_W'(want.speaker_gate));
                    check_field("divisor", got.divisor, want.divisor);
                    check_field("phase", DIV_W'(got.phase), DIV_W'(want.phase));
                    check_field("note_done", DIV_W'(got.note_done), DIV_W'(want.note_done));
                    check_field("rejected", DIV_W'(got.rejected), DIV_W'(want.rejected));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CLOCK_HZ:    clock_hz_cfg = cfg_data[CLOCK_HZ_W-1:0];
                    REG_MS_PER_TICK: mpt_cfg = cfg_data[MPT_W-1:0];
                    REG_GAP_TICKS:   gap_cfg = cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = next_player_output(s_op, s_freq_hz, s_note_ms, s_more_notes);
                if (want.note_done) finished++;
                if (want.rejected) rejected_cnt++;
                pending_outputs.push_back(want);
            end
        end
        outstanding <= pending_outputs.size();
        fail_count <= errors;
        notes_finished <= finished;
        notes_rejected <= rejected_cnt;
    end

endmodule

// ----- test/tb_tone_note_player.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tone note player testbench
// Plays directed notes, rests and ticks under default settings, then random note
// sequences under several register settings, extremes included, with random gaps
// on both channels bar the last run. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_tone_note_player;
    import tnp_pkg::*;
    import tnp_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_op;
    logic [FREQ_W-1:0]     s_freq_hz;
    logic [DUR_W-1:0]      s_note_ms;
    logic                  s_more_notes;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_speaker_gate;
    logic [DIV_W-1:0]      m_divisor;
    logic [PHASE_W-1:0]    m_phase;
    logic                  m_note_done;
    logic                  m_rejected;

    int fail_count;
    int outstanding;
    int notes_finished;
    int notes_rejected;

    bit          send_idle;
    bit          recv_idle;
    int          items_sent;
    int          notes_sent;
    int          settings_used;
    int          idle_cycles;
    int unsigned cur_mpt;
    int unsigned cur_gap;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tone_note_player u_dut (.*);

    tone_note_checker u_chk (.*);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles.", idle_cycles);
            $display("tb_tone_note_player failed");
            $finish;
        end
    end

    initial begin
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (recv_idle && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send(input logic op, input logic [FREQ_W-1:0] freq,
                        input logic [DUR_W-1:0] dur, input logic more);
        if (send_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_op <= op;
        s_freq_hz <= freq;
        s_note_ms <= dur;
        s_more_notes <= more;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (op == OP_NOTE) notes_sent++;
    endtask

    task automatic send_tick();
        send(OP_TICK, FREQ_W'($urandom_range(0, 65535)), DUR_W'($urandom_range(0, 65535)),
             1'($urandom_range(0, 1)));
    endtask

    // Call right after a transfer step; the first edge lets the checker count it.
    task automatic wait_drained();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] clk_hz,
                              input logic [CFG_DATA_W-1:0] mpt,
                              input logic [CFG_DATA_W-1:0] gap);
        logic [CFG_IDX_W-1:0]  idx[3];
        logic [CFG_DATA_W-1:0] val[3];
        idx = '{REG_CLOCK_HZ, REG_MS_PER_TICK, REG_GAP_TICKS};
        val = '{clk_hz, mpt, gap};
        s_valid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_mpt = 32'(mpt[MPT_W-1:0]);
        cur_gap = 32'(gap[GAP_W-1:0]);
        settings_used++;
    endtask

    task automatic play_sequence();
        int unsigned      step_ms;
        int unsigned      span;
        int unsigned      count;
        int               shape;
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
        logic              more;
        step_ms = (cur_mpt == 0) ? 1 : cur_mpt;
        case ($urandom_range(0, 5))
            0: freq = '0;
            1: freq = $urandom_range(0, 1) ? 16'd1 : 16'hFFFF;
            default: freq = FREQ_W'($urandom_range(1, 65535));
        endcase
        if (step_ms >= 500 && $urandom_range(0, 3) == 0) begin
            dur = DUR_W'($urandom_range(0, 65535));
        end else begin
            dur = DUR_W'(step_ms * $urandom_range(0, 5) + $urandom_range(0, step_ms - 1));
        end
        more = 1'($urandom_range(0, 1));
        span = 32'(dur) / step_ms;
        if (span == 0) span = 1;
        if (more && cur_gap > 0) span += cur_gap;
        shape = $urandom_range(0, 9);
        if (shape == 0) count = $urandom_range(0, span - 1);
        else if (shape == 1) count = span + $urandom_range(1, 3);
        else count = span;
        if ($urandom_range(0, 19) == 0) begin
            s_valid <= 1'b0;
            wait_drained();
        end
        send(OP_NOTE, freq, dur, more);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                send(OP_NOTE, FREQ_W'($urandom_range(0, 65535)),
                     DUR_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            end
            send_tick();
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] clk_hz,
                             input logic [CFG_DATA_W-1:0] mpt,
                             input logic [CFG_DATA_W-1:0] gap, input int budget);
        int start;
        set_config(clk_hz, mpt, gap);
        start = items_sent;
        while (items_sent - start < budget) play_sequence();
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_CLOCK_HZ;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_op <= OP_TICK;
        s_freq_hz <= '0;
        s_note_ms <= '0;
        s_more_notes <= 1'b0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        cur_mpt = 32'(MPT_RESET);
        cur_gap = 32'(GAP_RESET);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default settings: idle tick, tone with gap and a rejected note,
        // a short rest, the divisor clamp at the top end, and the highest frequency.
        send(OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
        send(OP_NOTE, 16'd440, 16'd20, 1'b1);
        send(OP_NOTE, 16'd1000, 16'd50, 1'b0);
        repeat (4) send_tick();
        send(OP_NOTE, 16'd0, 16'd0, 1'b0);
        send_tick();
        send(OP_NOTE, 16'd1, 16'd9, 1'b0);
        send_tick();
        send(OP_NOTE, 16'hFFFF, 16'd10, 1'b1);
        repeat (3) send_tick();
        send(OP_TICK, 16'd0, 16'd0, 1'b0);

        run_phase(24'hFFFFFF, 24'd1000, 24'd255, 20);
        run_phase(24'd1, 24'd1, 24'd0, 50);
        run_phase(24'd0, 24'd0, 24'd1, 40);
        repeat (4) begin
            run_phase(CFG_DATA_W'($urandom_range(1, 24'hFFFFFF)),
                      CFG_DATA_W'($urandom_range(1, 1000)),
                      CFG_DATA_W'($urandom_range(0, 6)), 35);
        end
        send_idle = 1'b0;
        recv_idle = 1'b0;
        run_phase(CLOCK_HZ_RESET, CFG_DATA_W'($urandom_range(1, 50)),
                  CFG_DATA_W'($urandom_range(0, 3)), 40);

        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d items (%0d notes) across %0d register settings.",
                 items_sent, notes_sent, settings_used);
        $display("Notes finished: %0d, notes rejected while busy: %0d.",
                 notes_finished, notes_rejected);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_tone_note_player passed");
        end else begin
            $display("tb_tone_note_player failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tnp_pkg.sv
rtl/core/tnp_front.sv
rtl/core/tnp_queue.sv
rtl/core/tnp_back.sv
rtl/core/tone_note_player.sv
test/tnp_tb_pkg.sv
test/tone_note_checker.sv
test/tb_tone_note_player.sv
